// ===== src/ciq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ciq_pkg
// Shared types and constants for the circular queue with search.
// ----------------------------------------------------------------------------
package ciq_pkg;

  localparam int OpW     = 3;
  localparam int DataW   = 32;
  localparam int StatusW = 2;
  localparam int CountW  = 7;
  localparam int CapW    = 7;
  localparam int DefDepth = 64;

  typedef enum logic [OpW-1:0] {
    OP_ENQ    = 3'd0,
    OP_DEQ    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_SEARCH = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_SCAN = 2'd2
  } ctrl_state_e;

  typedef struct packed {
    logic [OpW-1:0]           op;
    logic signed [DataW-1:0]  value;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0]       status;
    logic signed [DataW-1:0]  data;
    logic [CountW-1:0]        position;
    logic [CountW-1:0]        count;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // take the request on the ports
    logic rd_done;    // head word is in the read register
    logic scan_next;  // step search to the next entry
    logic scan_hit;   // finish search with a match
    logic scan_miss;  // finish search without a match
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic needs_read;
    logic needs_scan;
    logic match;
    logic scan_last;
  } dp_sts_t;

endpackage

// ===== src/ciq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ciq_ctrl
// Sequencer: accepts requests, waits on memory reads and walks searches.
// ----------------------------------------------------------------------------
module ciq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  ciq_pkg::dp_sts_t sts_i,
  output ciq_pkg::dp_cmd_t cmd_o,
  output logic             busy_o
);

  ciq_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ciq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      ciq_pkg::S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.needs_read) begin
            state_d = ciq_pkg::S_READ;
          end else if (sts_i.needs_scan) begin
            state_d = ciq_pkg::S_SCAN;
          end
        end
      end
      ciq_pkg::S_READ: begin
        cmd_o.rd_done = 1'b1;
        state_d       = ciq_pkg::S_IDLE;
      end
      ciq_pkg::S_SCAN: begin
        if (sts_i.match) begin
          cmd_o.scan_hit = 1'b1;
          state_d        = ciq_pkg::S_IDLE;
        end else if (sts_i.scan_last) begin
          cmd_o.scan_miss = 1'b1;
          state_d         = ciq_pkg::S_IDLE;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      default: begin
        state_d = ciq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/ciq_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ciq_datapath
// Storage, head/tail/count registers, capacity register, search compare
// and the result register.
// ----------------------------------------------------------------------------
module ciq_datapath #(
  parameter int Depth = ciq_pkg::DefDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ciq_pkg::CapW-1:0]   cfg_wdata_i,
  input  ciq_pkg::req_t              req_i,
  input  ciq_pkg::dp_cmd_t           cmd_i,
  output ciq_pkg::dp_sts_t           sts_o,
  output ciq_pkg::res_t              res_o,
  output logic                       done_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int XW = ((AW > ciq_pkg::CapW) ? AW : ciq_pkg::CapW) + 1;
  localparam int CapMax = (1 << ciq_pkg::CapW) - 1;
  localparam int CapRst = (Depth > CapMax) ? CapMax : Depth;

  logic [ciq_pkg::CapW-1:0]   cap_q, cap_d;
  logic [AW-1:0]              head_q, head_d, tail_q, tail_d;
  logic [AW-1:0]              scan_idx_q, scan_idx_d;
  logic [ciq_pkg::CountW-1:0] cnt_q, cnt_d, scan_i_q, scan_i_d;
  logic [ciq_pkg::DataW-1:0]  key_q, key_d;
  logic [ciq_pkg::DataW-1:0]  rdata_q;
  ciq_pkg::res_t              res_q, res_d;
  logic                       done_q, done_d;

  logic [ciq_pkg::DataW-1:0]  mem [Depth];
  logic                       mem_we, mem_re;
  logic [AW-1:0]              raddr;

  logic                       empty, full;

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx,
                                            input logic [ciq_pkg::CapW-1:0] cap);
    logic [XW-1:0] nxt;
    nxt = XW'(idx) + XW'(1);
    return (nxt >= XW'(cap)) ? '0 : nxt[AW-1:0];
  endfunction

  assign empty = (cnt_q == '0);
  assign full  = (cnt_q >= cap_q);

  always_comb begin
    sts_o            = '0;
    sts_o.needs_read = ((req_i.op == ciq_pkg::OP_DEQ) || (req_i.op == ciq_pkg::OP_PEEK))
                       && !empty;
    sts_o.needs_scan = (req_i.op == ciq_pkg::OP_SEARCH) && !empty;
    sts_o.match      = (rdata_q == key_q);
    sts_o.scan_last  = (scan_i_q == (cnt_q - ciq_pkg::CountW'(1)));
  end

  always_comb begin
    cap_d      = cap_q;
    head_d     = head_q;
    tail_d     = tail_q;
    cnt_d      = cnt_q;
    scan_idx_d = scan_idx_q;
    scan_i_d   = scan_i_q;
    key_d      = key_q;
    res_d      = res_q;
    done_d     = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    raddr      = scan_idx_q;

    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        cap_d = ciq_pkg::CapW'(1);
      end else if (int'(cfg_wdata_i) > Depth) begin
        cap_d = ciq_pkg::CapW'(Depth);
      end else begin
        cap_d = cfg_wdata_i;
      end
      head_d = '0;
      tail_d = '0;
      cnt_d  = '0;
    end else if (cmd_i.accept) begin
      res_d = '0;
      res_d.status = ciq_pkg::ST_OK;
      res_d.count  = cnt_q;
      case (ciq_pkg::op_e'(req_i.op))
        ciq_pkg::OP_ENQ: begin
          done_d = 1'b1;
          if (full) begin
            res_d.status = ciq_pkg::ST_FULL;
          end else begin
            mem_we      = 1'b1;
            tail_d      = advance(tail_q, cap_q);
            cnt_d       = cnt_q + ciq_pkg::CountW'(1);
            res_d.count = cnt_d;
          end
        end
        ciq_pkg::OP_DEQ: begin
          if (empty) begin
            done_d       = 1'b1;
            res_d.status = ciq_pkg::ST_EMPTY;
          end else begin
            mem_re = 1'b1;
            raddr  = head_q;
            head_d = advance(head_q, cap_q);
            cnt_d  = cnt_q - ciq_pkg::CountW'(1);
          end
        end
        ciq_pkg::OP_PEEK: begin
          if (empty) begin
            done_d       = 1'b1;
            res_d.status = ciq_pkg::ST_EMPTY;
          end else begin
            mem_re = 1'b1;
            raddr  = head_q;
          end
        end
        ciq_pkg::OP_CLEAR: begin
          done_d      = 1'b1;
          head_d      = '0;
          tail_d      = '0;
          cnt_d       = '0;
          res_d.count = '0;
        end
        ciq_pkg::OP_SEARCH: begin
          key_d = req_i.value;
          if (empty) begin
            done_d       = 1'b1;
            res_d.status = ciq_pkg::ST_NOTFOUND;
          end else begin
            mem_re     = 1'b1;
            raddr      = head_q;
            scan_idx_d = advance(head_q, cap_q);
            scan_i_d   = '0;
          end
        end
        default: begin
          done_d = 1'b1;
        end
      endcase
    end else if (cmd_i.rd_done) begin
      done_d       = 1'b1;
      res_d        = '0;
      res_d.status = ciq_pkg::ST_OK;
      res_d.data   = rdata_q;
      res_d.count  = cnt_q;
    end else if (cmd_i.scan_hit) begin
      done_d         = 1'b1;
      res_d          = '0;
      res_d.status   = ciq_pkg::ST_OK;
      res_d.position = scan_i_q + ciq_pkg::CountW'(1);
      res_d.count    = cnt_q;
    end else if (cmd_i.scan_miss) begin
      done_d       = 1'b1;
      res_d        = '0;
      res_d.status = ciq_pkg::ST_NOTFOUND;
      res_d.count  = cnt_q;
    end else if (cmd_i.scan_next) begin
      // rdata_q holds entry scan_i; fetch the one after it
      mem_re     = 1'b1;
      raddr      = scan_idx_q;
      scan_idx_d = advance(scan_idx_q, cap_q);
      scan_i_d   = scan_i_q + ciq_pkg::CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= ciq_pkg::CapW'(CapRst);
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cap_q  <= cap_d;
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_idx_q <= scan_idx_d;
    scan_i_q   <= scan_i_d;
    key_q      <= key_d;
    res_q      <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[tail_q] <= req_i.value;
    end
    if (mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

// ===== src/circular_int_queue_with_search_top.sv =====
`timescale 1ns / 1ps
// Timing: enqueue, clear, unused codes and empty-queue requests: done_o rises in the cycle
//   after accept. Dequeue/peek: registered storage read, then S_READ, then done_o. Search:
//   one storage read per entry walked from head. busy_o is high while a read or walk is open.
// Throughput: one request per cycle while busy_o is low; results cannot be stalled.
// Reset: queue empty, capacity = DEPTH capped at 127; storage content is not cleared.
// ----------------------------------------------------------------------------
// circular_int_queue_with_search_top
// Ring-buffer FIFO of signed words with runtime capacity and linear search.
// ----------------------------------------------------------------------------
module circular_int_queue_with_search_top #(
  parameter int DEPTH = ciq_pkg::DefDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [ciq_pkg::CapW-1:0] cfg_wdata_i,
  input  logic                     start,
  input  ciq_pkg::req_t            req_i,
  output logic                     busy,
  output logic                     done_o,
  output ciq_pkg::res_t            res_o
);

  ciq_pkg::dp_cmd_t cmd;
  ciq_pkg::dp_sts_t sts;

  ciq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  ciq_datapath #(
    .Depth (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res_o),
    .done_o      (done_o)
  );

endmodule

// ===== tb/sv/circular_int_queue_with_search_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_int_queue_with_search_top_test
// Self-checking bench for the ring-buffer queue with search. Requests go out
// with random gaps and one long gap-free stretch. A local copy of the ring
// predicts each result, and every done_o beat is checked against the oldest
// prediction. Capacity is rewritten between phases, including saturating
// values.
// ----------------------------------------------------------------------------
module circular_int_queue_with_search_top_test;

  localparam int Depth = 64;
  // op codes the block treats as no-ops
  localparam logic [ciq_pkg::OpW-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [ciq_pkg::OpW-1:0] OP_SPARE_HI = 3'd7;
  // longest search walks the whole ring
  localparam int SettleCycles = Depth + 4;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_we_i    = 1'b0;
  logic [ciq_pkg::CapW-1:0] cfg_wdata_i = '0;
  logic                     start       = 1'b0;
  ciq_pkg::req_t            req_i       = '0;
  logic                     busy;
  logic                     done_o;
  ciq_pkg::res_t            res_o;

  // predicted ring contents and pointers
  logic signed [ciq_pkg::DataW-1:0] ring_mem [Depth];
  int unsigned ring_cap;
  int unsigned ring_head;
  int unsigned ring_tail;
  int unsigned ring_count;

  ciq_pkg::res_t expected_res[$];
  int unsigned   err_cnt = 0;
  bit            gaps_on = 1'b1;

  always #4 clk_i = ~clk_i;

  circular_int_queue_with_search_top #(
    .DEPTH(Depth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .start      (start),
    .req_i      (req_i),
    .busy       (busy),
    .done_o     (done_o),
    .res_o      (res_o)
  );

  function automatic int unsigned next_slot(input int unsigned idx);
    return (idx + 1 >= ring_cap) ? 0 : idx + 1;
  endfunction

  function automatic void empty_ring();
    ring_head  = 0;
    ring_tail  = 0;
    ring_count = 0;
  endfunction

  // updates the ring copy and returns the result the request should produce
  function automatic ciq_pkg::res_t predict_queue_op(input ciq_pkg::req_t r);
    ciq_pkg::res_t o;
    int unsigned   idx;
    o        = '0;
    o.status = ciq_pkg::ST_OK;
    case (r.op)
      ciq_pkg::OP_ENQ: begin
        if (ring_count >= ring_cap) begin
          o.status = ciq_pkg::ST_FULL;
        end else begin
          ring_mem[ring_tail] = r.value;
          ring_tail = next_slot(ring_tail);
          ring_count++;
        end
      end
      ciq_pkg::OP_DEQ: begin
        if (ring_count == 0) begin
          o.status = ciq_pkg::ST_EMPTY;
        end else begin
          o.data = ring_mem[ring_head];
          ring_head = next_slot(ring_head);
          ring_count--;
        end
      end
      ciq_pkg::OP_PEEK: begin
        if (ring_count == 0) o.status = ciq_pkg::ST_EMPTY;
        else o.data = ring_mem[ring_head];
      end
      ciq_pkg::OP_CLEAR: empty_ring();
      ciq_pkg::OP_SEARCH: begin
        o.status = ciq_pkg::ST_NOTFOUND;
        idx = ring_head;
        for (int unsigned i = 0; i < ring_count; i++) begin
          if (o.status == ciq_pkg::ST_NOTFOUND && ring_mem[idx] == r.value) begin
            o.status   = ciq_pkg::ST_OK;
            o.position = ciq_pkg::CountW'(i + 1);
          end
          idx = next_slot(idx);
        end
      end
      default: ;
    endcase
    o.count = ciq_pkg::CountW'(ring_count);
    return o;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic [ciq_pkg::OpW-1:0] op,
                              input logic signed [ciq_pkg::DataW-1:0] value);
    ciq_pkg::req_t r;
    r.op    = op;
    r.value = value;
    if (gaps_on && $urandom_range(99) < 11) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1;
    req_i = r;
    do @(posedge clk_i); while (busy);
    expected_res.push_back(predict_queue_op(r));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    start = 1'b0;
    while (expected_res.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic set_capacity(input logic [ciq_pkg::CapW-1:0] cap);
    int unsigned v;
    drain_results();
    cfg_wdata_i = cap;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    v = cap;
    if (v < 1) v = 1;
    if (v > Depth) v = Depth;
    ring_cap = v;
    empty_ring();
  endtask

  // swings between filling and draining so full and empty both come up often
  task automatic random_items(input int unsigned n);
    bit                               filling;
    int unsigned                      pick;
    int unsigned                      k;
    int unsigned                      idx;
    logic [ciq_pkg::OpW-1:0]          op;
    logic signed [ciq_pkg::DataW-1:0] value;
    filling = 1'b1;
    for (int unsigned i = 0; i < n; i++) begin
      if (ring_count >= ring_cap && $urandom_range(2) == 0) filling = 1'b0;
      if (ring_count == 0 && $urandom_range(2) == 0) filling = 1'b1;
      case ($urandom_range(3))
        0: value = $urandom_range(7);
        1: begin
          case ($urandom_range(3))
            0: value = 32'sh8000_0000;
            1: value = 32'sh7fff_ffff;
            2: value = -1;
            default: value = 0;
          endcase
        end
        default: value = $urandom;
      endcase
      pick = $urandom_range(99);
      if (pick < 3) op = ciq_pkg::OP_CLEAR;
      else if (pick < 6) op = ciq_pkg::OpW'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      else if (pick < 20) op = ciq_pkg::OP_PEEK;
      else if (pick < 35) op = ciq_pkg::OP_SEARCH;
      else if (pick < (filling ? 90 : 45)) op = ciq_pkg::OP_ENQ;
      else op = ciq_pkg::OP_DEQ;
      // mostly search for something that is stored, often the tail entry
      if (op == ciq_pkg::OP_SEARCH && ring_count > 0 && $urandom_range(9) < 7) begin
        k = $urandom_range(1) ? ring_count - 1 : $urandom_range(ring_count - 1);
        idx = ring_head;
        repeat (k) idx = next_slot(idx);
        value = ring_mem[idx];
      end
      send_request(op, value);
    end
  endtask

  task automatic test_empty_and_extremes();
    send_request(ciq_pkg::OP_PEEK, 0);
    send_request(ciq_pkg::OP_DEQ, 0);
    send_request(ciq_pkg::OP_SEARCH, 0);
    send_request(ciq_pkg::OP_ENQ, 32'sh8000_0000);
    send_request(ciq_pkg::OP_ENQ, 32'sh7fff_ffff);
    send_request(ciq_pkg::OP_ENQ, -1);
    send_request(ciq_pkg::OP_PEEK, 0);
    send_request(ciq_pkg::OP_SEARCH, 32'sh7fff_ffff);
    send_request(ciq_pkg::OP_SEARCH, 0);
    send_request(ciq_pkg::OP_DEQ, 0);
    send_request(OP_SPARE_LO, -1);
    send_request(OP_SPARE_HI, 0);
    send_request(ciq_pkg::OP_CLEAR, 0);
    send_request(ciq_pkg::OP_DEQ, 0);
  endtask

  task automatic test_full_and_wrap();
    set_capacity(7'd3);
    send_request(ciq_pkg::OP_ENQ, 11);
    send_request(ciq_pkg::OP_ENQ, 22);
    send_request(ciq_pkg::OP_ENQ, 33);
    send_request(ciq_pkg::OP_ENQ, 44);
    send_request(ciq_pkg::OP_SEARCH, 33);
    send_request(ciq_pkg::OP_DEQ, 0);
    send_request(ciq_pkg::OP_ENQ, 44);
    send_request(ciq_pkg::OP_SEARCH, 44);
    send_request(ciq_pkg::OP_PEEK, 0);
    send_request(ciq_pkg::OP_SEARCH, 11);
  endtask

  task automatic test_back_to_back();
    set_capacity(7'd127);
    gaps_on = 1'b0;
    random_items(400);
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [ciq_pkg::CapW-1:0] caps [9] = '{7'd0, 7'd1, 7'd2, 7'd5, 7'd17, 7'd64, 7'd65,
                                          7'd33, 7'd63};
    foreach (caps[c]) begin
      set_capacity(caps[c]);
      random_items(180);
    end
  endtask

  always @(posedge clk_i) begin
    ciq_pkg::res_t want;
    if (rst_ni && done_o) begin
      if (expected_res.size() == 0) begin
        $display("%0t: unexpected result status=%0d data=%0d position=%0d count=%0d",
                 $time, res_o.status, res_o.data, res_o.position, res_o.count);
        err_cnt++;
      end else begin
        want = expected_res.pop_front();
        if (res_o.status !== want.status || res_o.data !== want.data ||
            res_o.position !== want.position || res_o.count !== want.count) begin
          $display("%0t: mismatch exp status=%0d data=%0d position=%0d count=%0d",
                   $time, want.status, want.data, want.position, want.count);
          $display("%0t:          got status=%0d data=%0d position=%0d count=%0d",
                   $time, res_o.status, res_o.data, res_o.position, res_o.count);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("circular_int_queue_with_search_top_test: done, errors");
    $finish;
  end

  initial begin
    ring_cap = Depth;
    empty_ring();
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    test_empty_and_extremes();
    test_full_and_wrap();
    test_back_to_back();
    test_random_traffic();
    drain_results();
    repeat (SettleCycles) @(negedge clk_i);
    if (err_cnt == 0 && expected_res.size() == 0) begin
      $display("circular_int_queue_with_search_top_test: done, clean");
    end else begin
      $display("circular_int_queue_with_search_top_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ciq_pkg.sv
src/ciq_ctrl.sv
src/ciq_datapath.sv
src/circular_int_queue_with_search_top.sv
tb/sv/circular_int_queue_with_search_top_test.sv
